/* src/weighted_pixel_blend_top_macros.svh */
// assertion macros shared by the blend modules
`ifndef WEIGHTED_PIXEL_BLEND_TOP_MACROS_SVH
`define WEIGHTED_PIXEL_BLEND_TOP_MACROS_SVH
`ifndef SYNTHESIS
// condition must hold in the same cycle
`define WPB_ASSERT_HOLDS(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wpb check failed: same-cycle condition");
// condition must hold in the following cycle
`define WPB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wpb check failed: next-cycle condition");
`else
`define WPB_ASSERT_HOLDS(lbl, clk, rst, ante, cons)
`define WPB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* src/wpb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package wpb_pkg;

  localparam int MAX_IMAGES       = 8;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam int COORD_W  = 13;
  localparam int CHAN_W   = 8;
  localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;
  localparam int IMG_BITS = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
  localparam int CSUM_W   = CHAN_W + WEIGHT_W + IMG_BITS;
  localparam int WSUM_W   = WEIGHT_W + IMG_BITS;
  localparam int PROD_W   = CHAN_W + WEIGHT_W;

  // restoring divider: one saturation step plus one step per colour bit
  localparam int DIV_STEPS = CHAN_W + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int NUM_W     = CSUM_W + 2;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [0:0] REG_IGNORE_WEIGHTS = 1'b0;

  localparam logic [CHAN_W-1:0]   ALPHA_THRESHOLD = 8'd127;
  localparam logic [CHAN_W-1:0]   CHANNEL_MAX     = 8'd255;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;

  typedef struct packed {
    logic signed [COORD_W-1:0] local_x;
    logic signed [COORD_W-1:0] local_y;
    logic [COORD_W-1:0]        src_width;
    logic [COORD_W-1:0]        src_height;
    logic [CHAN_W-1:0]         sample_blue;
    logic [CHAN_W-1:0]         sample_green;
    logic [CHAN_W-1:0]         sample_red;
    logic [CHAN_W-1:0]         sample_alpha;
    logic [WEIGHT_W-1:0]       weight;
    logic                      last_image;
  } item_t;

  typedef struct packed {
    logic [CSUM_W-1:0] blue;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] red;
    logic [WSUM_W-1:0] total;
  } sums_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

/* src/wpb_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module wpb_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           ignore_weights,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire wpb_pkg::item_t in_item,
  input  wire wpb_pkg::queue_stat_t q_stat,
  output logic                push,
  output wpb_pkg::sums_t      push_data
);
  import wpb_pkg::*;

  // classify stage
  logic                v1;
  logic [WEIGHT_W-1:0] k1;
  logic [CHAN_W-1:0]   b1, g1, r1;
  logic                last1;
  // product stage
  logic                v2;
  logic [WEIGHT_W-1:0] k2;
  logic [PROD_W-1:0]   pb2, pg2, pr2;
  logic                last2;
  // running sums
  logic [CSUM_W-1:0]   blue_sum, green_sum, red_sum;
  logic [WSUM_W-1:0]   weight_total;

  logic                in_image;
  logic [WEIGHT_W-1:0] k_sel;
  logic                fire2, en2, en1;
  logic [CSUM_W:0]     b_add, g_add, r_add;
  logic [WSUM_W:0]     w_add;
  sums_t               sums_new;

  always_comb begin
    in_image = !in_item.local_x[COORD_W-1] && !in_item.local_y[COORD_W-1]
            && ($unsigned(in_item.local_x) < in_item.src_width)
            && ($unsigned(in_item.local_y) < in_item.src_height);
    if (ignore_weights) begin
      k_sel = (in_item.sample_alpha > ALPHA_THRESHOLD) ? WEIGHT_ONE : '0;
    end else begin
      k_sel = in_item.weight;
    end
    if (!in_image) begin
      k_sel = '0;
    end
  end

  assign fire2    = v2 && (!last2 || !q_stat.full);
  assign en2      = !v2 || fire2;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // saturating accumulate
  always_comb begin
    b_add = {1'b0, blue_sum} + (CSUM_W+1)'(pb2);
    g_add = {1'b0, green_sum} + (CSUM_W+1)'(pg2);
    r_add = {1'b0, red_sum} + (CSUM_W+1)'(pr2);
    w_add = {1'b0, weight_total} + (WSUM_W+1)'(k2);
    sums_new.blue  = b_add[CSUM_W] ? '1 : b_add[CSUM_W-1:0];
    sums_new.green = g_add[CSUM_W] ? '1 : g_add[CSUM_W-1:0];
    sums_new.red   = r_add[CSUM_W] ? '1 : r_add[CSUM_W-1:0];
    sums_new.total = w_add[WSUM_W] ? '1 : w_add[WSUM_W-1:0];
  end

  assign push      = fire2 && last2;
  assign push_data = sums_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      blue_sum     <= '0;
      green_sum    <= '0;
      red_sum      <= '0;
      weight_total <= '0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (fire2) begin
        if (last2) begin
          blue_sum     <= '0;
          green_sum    <= '0;
          red_sum      <= '0;
          weight_total <= '0;
        end else begin
          blue_sum     <= sums_new.blue;
          green_sum    <= sums_new.green;
          red_sum      <= sums_new.red;
          weight_total <= sums_new.total;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      k1    <= k_sel;
      b1    <= in_item.sample_blue;
      g1    <= in_item.sample_green;
      r1    <= in_item.sample_red;
      last1 <= in_item.last_image;
    end
    if (en2 && v1) begin
      k2    <= k1;
      pb2   <= PROD_W'(k1) * PROD_W'(b1);
      pg2   <= PROD_W'(k1) * PROD_W'(g1);
      pr2   <= PROD_W'(k1) * PROD_W'(r1);
      last2 <= last1;
    end
  end

endmodule
`default_nettype wire

/* src/wpb_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_pixel_blend_top_macros.svh"
module wpb_queue #(
  parameter int DEPTH = wpb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire wpb_pkg::sums_t  push_data,
  input  wire logic            pop,
  output wpb_pkg::sums_t       pop_data,
  output wpb_pkg::queue_stat_t stat
);
  import wpb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sums_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `WPB_ASSERT_HOLDS(a_no_overflow, clk, rst, push, !stat.full)
  `WPB_ASSERT_HOLDS(a_no_underflow, clk, rst, pop, !stat.empty)
  `WPB_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + CNT_W'(1))

endmodule
`default_nettype wire

/* src/wpb_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_pixel_blend_top_macros.svh"
module wpb_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_valid,
  output logic                         q_pop,
  input  wire wpb_pkg::sums_t          q_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [wpb_pkg::CHAN_W-1:0]   out_blue,
  output logic [wpb_pkg::CHAN_W-1:0]   out_green,
  output logic [wpb_pkg::CHAN_W-1:0]   out_red,
  output logic [wpb_pkg::CHAN_W-1:0]   out_alpha,
  output logic                         out_covered
);
  import wpb_pkg::*;

  back_state_t       state, state_next;
  logic [STEP_W-1:0] cnt;
  logic [NUM_W-1:0]  rem [3];
  logic [CHAN_W:0]   quo [3];
  logic [NUM_W-1:0]  dsh;
  logic              covered;
  logic              out_load;
  logic [CSUM_W-1:0] chan_sum [3];
  logic [CHAN_W-1:0] chan_res [3];

  assign chan_sum[0] = q_data.blue;
  assign chan_sum[1] = q_data.green;
  assign chan_sum[2] = q_data.red;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (q_valid) state_next = BK_DIV;
      BK_DIV:  if (cnt == '0) state_next = BK_DONE;
      BK_DONE: if (!out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state)
      BK_IDLE: q_pop = q_valid;
      BK_DIV:  ;
      BK_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // top quotient bit set means the quotient reached 256
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan_res[c] = quo[c][CHAN_W] ? CHANNEL_MAX : quo[c][CHAN_W-1:0];
      if (!covered) begin
        chan_res[c] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int c = 0; c < 3; c++) begin
        rem[c] <= {1'b0, chan_sum[c], 1'b0} + NUM_W'(q_data.total);
        quo[c] <= '0;
      end
      dsh     <= NUM_W'({q_data.total, 1'b0}) << CHAN_W;
      cnt     <= STEP_W'(DIV_STEPS - 1);
      covered <= (q_data.total != '0);
    end else if (state == BK_DIV) begin
      for (int c = 0; c < 3; c++) begin
        if (rem[c] >= dsh) begin
          rem[c] <= rem[c] - dsh;
          quo[c] <= {quo[c][CHAN_W-1:0], 1'b1};
        end else begin
          quo[c] <= {quo[c][CHAN_W-1:0], 1'b0};
        end
      end
      dsh <= dsh >> 1;
      cnt <= cnt - STEP_W'(1);
    end
    if (out_load) begin
      out_blue    <= chan_res[0];
      out_green   <= chan_res[1];
      out_red     <= chan_res[2];
      out_alpha   <= covered ? CHANNEL_MAX : '0;
      out_covered <= covered;
    end
  end

  `WPB_ASSERT_HOLDS(a_pop_idle, clk, rst, q_pop, state == BK_IDLE)
  `WPB_ASSERT_HOLDS(a_step_range, clk, rst, state == BK_DIV, cnt < STEP_W'(DIV_STEPS))
  `WPB_ASSERT_NEXT(a_out_load, clk, rst, out_load, out_valid)
  `WPB_ASSERT_HOLDS(a_cover_alpha, clk, rst, out_valid, out_covered == (out_alpha == CHANNEL_MAX))

endmodule
`default_nettype wire

/* src/weighted_pixel_blend_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  transaction
// s_axis    in   one source-image sample for the current output pixel, tlast = last image
// m_axis    out  one blended pixel, tuser = covered
// apb       in   register writes and reads, one register (ignore_weights)
//
// cycles: a sample is taken every cycle unless the front stalls; it passes a classify
//   stage and a product stage before it reaches the running sums
// the last sample of a pixel hands the sums to a small queue; the divider behind it
//   takes one pixel at a time: pop, 9 restoring steps, output load
// reset: synchronous, clears sums, queue, divider state, output valid and the register
// stalls: the front stalls only when a last sample meets a full queue; the output
//   register lets the divider finish while the sink holds off
module weighted_pixel_blend_top #(
  parameter int QUEUE_DEPTH = wpb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // local_x[12:0], local_y[25:13], src_width[38:26], src_height[51:39],
  // sample_blue[59:52], sample_green[67:60], sample_red[75:68],
  // sample_alpha[83:76], weight[100:84], zero fill[103:101]
  input  wire logic [wpb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic                            s_axis_tlast,
  // out_blue[7:0], out_green[15:8], out_red[23:16], out_alpha[31:24]
  output logic [wpb_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // covered[0]
  output logic                                 m_axis_tuser,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wpb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import wpb_pkg::*;

  logic               ignore_weights;
  item_t              item;
  logic               push, pop;
  sums_t              push_data, pop_data;
  queue_stat_t        q_stat;
  logic [CHAN_W-1:0]  out_blue, out_green, out_red, out_alpha;
  logic               out_covered;

  // unpack the input transaction
  assign item.local_x      = s_axis_tdata[12:0];
  assign item.local_y      = s_axis_tdata[25:13];
  assign item.src_width    = s_axis_tdata[38:26];
  assign item.src_height   = s_axis_tdata[51:39];
  assign item.sample_blue  = s_axis_tdata[59:52];
  assign item.sample_green = s_axis_tdata[67:60];
  assign item.sample_red   = s_axis_tdata[75:68];
  assign item.sample_alpha = s_axis_tdata[83:76];
  assign item.weight       = s_axis_tdata[100:84];
  assign item.last_image   = s_axis_tlast;

  // register port: always ready, word index sits above the byte bits
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_weights <= 1'b0;
    end else if (psel && penable && pwrite
                 && paddr[CFG_ADDR_W-1:2] == REG_IGNORE_WEIGHTS) begin
      ignore_weights <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1:2] == REG_IGNORE_WEIGHTS) begin
      prdata = {31'b0, ignore_weights};
    end
  end

  // front: classify, weight products, saturating sums
  wpb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .ignore_weights (ignore_weights),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_item        (item),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  // finished pixel sums waiting for the divider
  wpb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // back: rounding divide, saturation and output register
  wpb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (!q_stat.empty),
    .q_pop       (pop),
    .q_data      (pop_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_blue    (out_blue),
    .out_green   (out_green),
    .out_red     (out_red),
    .out_alpha   (out_alpha),
    .out_covered (out_covered)
  );

  assign m_axis_tdata = {out_alpha, out_red, out_green, out_blue};
  assign m_axis_tuser = out_covered;

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

// predicts blended pixels from accepted samples and checks the block's output
class blend_scoreboard;
  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       covered;
  } pixel_t;

  bit              ignore_weights;
  longint unsigned csum_max = (64'd1 << wpb_pkg::CSUM_W) - 1;
  longint unsigned wsum_max = (64'd1 << wpb_pkg::WSUM_W) - 1;
  longint unsigned blue_acc;
  longint unsigned green_acc;
  longint unsigned red_acc;
  longint unsigned weight_acc;
  bit              hit_limit;
  pixel_t          expected_pixels[$];
  int              errors;
  int              pixels_checked;
  int              covered_pixels;
  int              saturated_pixels;

  function int pending();
    return expected_pixels.size();
  endfunction

  function longint unsigned sat_sum(longint unsigned acc, longint unsigned add,
                                    longint unsigned lim);
    if (acc + add > lim) begin
      hit_limit = 1;
      return lim;
    end
    return acc + add;
  endfunction

  // quotient rounded half up, limited to full scale
  function logic [7:0] blend_channel(longint unsigned sum);
    longint unsigned q;
    q = (2 * sum + weight_acc) / (2 * weight_acc);
    return (q > wpb_pkg::CHANNEL_MAX) ? wpb_pkg::CHANNEL_MAX : q[7:0];
  endfunction

  function void add_sample(wpb_pkg::item_t s);
    int              lx;
    int              ly;
    int              w;
    int              h;
    longint unsigned k;
    pixel_t          px;
    lx = $signed(s.local_x);
    ly = $signed(s.local_y);
    w  = s.src_width;
    h  = s.src_height;
    if (lx >= 0 && lx < w && ly >= 0 && ly < h) begin
      if (ignore_weights)
        k = (s.sample_alpha > wpb_pkg::ALPHA_THRESHOLD) ? wpb_pkg::WEIGHT_ONE : 0;
      else
        k = s.weight;
      blue_acc   = sat_sum(blue_acc, k * s.sample_blue, csum_max);
      green_acc  = sat_sum(green_acc, k * s.sample_green, csum_max);
      red_acc    = sat_sum(red_acc, k * s.sample_red, csum_max);
      weight_acc = sat_sum(weight_acc, k, wsum_max);
    end
    if (s.last_image) begin
      if (weight_acc != 0) begin
        px = '{blend_channel(blue_acc), blend_channel(green_acc), blend_channel(red_acc),
               wpb_pkg::CHANNEL_MAX, 1'b1};
        covered_pixels++;
      end else begin
        px = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
      end
      if (hit_limit)
        saturated_pixels++;
      expected_pixels.push_back(px);
      blue_acc   = 0;
      green_acc  = 0;
      red_acc    = 0;
      weight_acc = 0;
      hit_limit  = 0;
    end
  endfunction

  function void compare(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_pixel(logic [31:0] data, logic covered);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      $display("%0t: pixel %h covered %b arrived, expected none", $time, data, covered);
      errors++;
      return;
    end
    want = expected_pixels.pop_front();
    pixels_checked++;
    compare("out_blue", want.blue, data[7:0]);
    compare("out_green", want.green, data[15:8]);
    compare("out_red", want.red, data[23:16]);
    compare("out_alpha", want.alpha, data[31:24]);
    compare("covered", 8'(want.covered), 8'(covered));
  endfunction
endclass

module testbench;
  import wpb_pkg::*;

  // run shape
  localparam int DRAIN_CYCLES   = 40;    // front stages plus one full divide, with margin
  localparam int HOLD_AFTER     = 30;    // pixels seen before the long sink hold-off
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on any port
  localparam int PHASE_SAMPLES  = 260;

  localparam logic [CFG_ADDR_W-1:0] ADDR_IGNORE_WEIGHTS = CFG_ADDR_W'(4 * REG_IGNORE_WEIGHTS);

  logic                   clk;
  logic                   rst;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic                   s_axis_tlast;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic                   m_axis_tuser;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  blend_scoreboard sb = new();
  int              samples_sent;
  int              mode_writes;

  weighted_pixel_blend_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    else if (r < 88)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // image size: mostly legal, a few tiny, a few with any 13-bit value
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(1, 4096);
    else if (r < 80)
      return $urandom_range(1, 4);
    else if (r < 90)
      return $urandom_range(0, 8191);
    return 4096;
  endfunction

  // a coordinate inside the image where that can be expressed
  function automatic int pick_inside(int size);
    if (size == 0)
      return $urandom_range(0, 4095);
    return $urandom_range(0, ((size > 4096) ? 4096 : size) - 1);
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic item_t sample_at(int x, int y, int w, int h, int b, int g, int r,
                                      int a, int wt, bit last);
    item_t s;
    s.local_x      = 13'(x);
    s.local_y      = 13'(y);
    s.src_width    = 13'(w);
    s.src_height   = 13'(h);
    s.sample_blue  = 8'(b);
    s.sample_green = 8'(g);
    s.sample_red   = 8'(r);
    s.sample_alpha = 8'(a);
    s.weight       = 17'(wt);
    s.last_image   = last;
    return s;
  endfunction

  // heavy samples carry near-maximum weight and opaque alpha to push the sums to their limit
  function automatic item_t make_sample(bit heavy, bit last);
    int w;
    int h;
    int x;
    int y;
    int a;
    int wt;
    w = pick_size();
    h = pick_size();
    x = pick_inside(w);
    y = pick_inside(h);
    // about one in five lands outside its image
    if ($urandom_range(0, 99) >= 80) begin
      case ($urandom_range(0, 4))
        0: x = -int'($urandom_range(1, 4096));
        1: y = -int'($urandom_range(1, 4096));
        2: x = (w <= 4095) ? w : -1;
        3: y = (h <= 4095) ? h : -1;
        default: begin
          x = $urandom_range(0, 8191);
          w = 0;
        end
      endcase
    end
    if (heavy) begin
      a  = $urandom_range(128, 255);
      wt = $urandom_range(98304, 131071);
    end else begin
      case ($urandom_range(0, 4))
        0:       a = ALPHA_THRESHOLD;
        1:       a = ALPHA_THRESHOLD + 1;
        default: a = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 9))
        0:       wt = 0;
        1:       wt = WEIGHT_ONE;
        2, 3:    wt = $urandom_range(0, 131071);
        4:       wt = $urandom_range(1, 16);
        default: wt = $urandom_range(0, 65536);
      endcase
    end
    return sample_at(x, y, w, h, pick_channel(), pick_channel(), pick_channel(), a, wt, last);
  endfunction

  // offer one sample after an optional gap and wait for its transaction
  task automatic send_sample(item_t s, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, s.weight, s.sample_alpha, s.sample_red, s.sample_green,
                      s.sample_blue, s.src_height, s.src_width, s.local_y, s.local_x};
    s_axis_tlast  <= s.last_image;
    do @(posedge clk); while (!s_axis_tready);
    sb.add_sample(s);
    samples_sent++;
  endtask

  // random pixels, each closed by a last sample, until the sample budget is spent
  task automatic run_random(int budget);
    int  sent;
    int  n;
    int  r;
    bit  heavy;
    bit  quiet;
    sent = 0;
    while (sent < budget) begin
      r     = $urandom_range(0, 99);
      heavy = (r < 5);
      if (heavy)
        n = $urandom_range(9, 20);
      else if (r < 15)
        n = $urandom_range(7, 12);
      else
        n = $urandom_range(1, 6);
      // some pixels go through back to back with no gaps at all
      quiet = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < n; i++)
        send_sample(make_sample(heavy, i == n - 1), quiet ? 0 : idle_len());
      sent += n;
    end
  endtask

  // stop offering, let every pixel come out, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // two-phase register write followed by a read back; only called with the block idle
  task automatic set_ignore_weights(bit value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_IGNORE_WEIGHTS;
    pwdata  <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.ignore_weights = value;
    mode_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'd0, value}) begin
      $display("%0t: ignore_weights read back mismatch, expected %0d, got %0d",
               $time, value, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stimulus
  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // weighted mode, directed corners first
    set_ignore_weights(1'b0);
    // single opaque sample at full weight and extreme colours
    send_sample(sample_at(0, 0, 1, 1, 255, 0, 170, 255, 65536, 1'b1), idle_len());
    // zero-size image gives an uncovered pixel
    send_sample(sample_at(0, 0, 0, 0, 12, 34, 56, 78, 65536, 1'b1), idle_len());
    // left of the image, on the right edge, on the bottom edge, most negative corner
    send_sample(sample_at(-1, 0, 10, 10, 255, 255, 255, 255, 65536, 1'b0), idle_len());
    send_sample(sample_at(10, 3, 10, 10, 255, 255, 255, 255, 65536, 1'b0), idle_len());
    send_sample(sample_at(3, 10, 10, 10, 255, 255, 255, 255, 65536, 1'b0), idle_len());
    send_sample(sample_at(-4096, -4096, 4096, 4096, 255, 255, 255, 255, 131071, 1'b0), 0);
    // last pixel of the largest image at the smallest nonzero weight
    send_sample(sample_at(4095, 4095, 4096, 4096, 100, 200, 50, 0, 1, 1'b1), idle_len());
    // exact halves must round up
    send_sample(sample_at(0, 0, 5, 5, 1, 3, 0, 0, 1, 1'b0), 0);
    send_sample(sample_at(1, 1, 5, 5, 0, 0, 0, 0, 1, 1'b1), 0);
    // inside, but nothing weighed in
    send_sample(sample_at(2, 2, 5, 5, 255, 255, 255, 255, 0, 1'b0), idle_len());
    send_sample(sample_at(3, 3, 5, 5, 255, 255, 255, 255, 0, 1'b1), idle_len());
    // more images than the sums were sized for, all at maximum weight
    for (int i = 0; i < 9; i++)
      send_sample(sample_at(i, i, 16, 16, 255, 255, 255, 255, 131071, i == 8), 0);
    run_random(PHASE_SAMPLES);
    drain();

    // alpha-threshold mode: just below, just above, nothing opaque
    set_ignore_weights(1'b1);
    send_sample(sample_at(2, 2, 4, 4, 10, 20, 30, ALPHA_THRESHOLD, 0, 1'b0), idle_len());
    send_sample(sample_at(0, 0, 4, 4, 200, 100, 50, ALPHA_THRESHOLD + 1, 0, 1'b1), 0);
    send_sample(sample_at(0, 0, 4, 4, 1, 1, 1, 0, 65536, 1'b1), idle_len());
    run_random(PHASE_SAMPLES);
    drain();

    set_ignore_weights(1'b0);
    run_random(PHASE_SAMPLES);
    drain();

    set_ignore_weights(1'b1);
    run_random(PHASE_SAMPLES);
    drain();

    $display("%0d samples sent, %0d pixels checked (%0d covered, %0d with a saturated sum)",
             samples_sent, sb.pixels_checked, sb.covered_pixels, sb.saturated_pixels);
    $display("mode register written %0d times across weighted and alpha-threshold phases",
             mode_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // sink: checks every pixel transaction, stalls at random, holds off once for a long stretch
  initial begin
    int stall_left;
    int ready_run;
    bit held;
    stall_left = 0;
    ready_run  = 0;
    held       = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_pixel(m_axis_tdata, m_axis_tuser);
      // long hold-off so the queue fills and the front has to stall
      if (!held && sb.pixels_checked >= HOLD_AFTER) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
        ready_run  = 0;
      end
      if (ready_run == 0 && stall_left == 0) begin
        ready_run  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 6);
        stall_left = idle_len();
      end
      if (ready_run > 0) begin
        m_axis_tready <= 1'b1;
        ready_run--;
      end else begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end
    end
  end

  // watchdog: a run with no transaction on any port for too long has hung
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles, %0d pixels outstanding",
                 $time, quiet_cycles, sb.pending());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
